// File: src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent checked in the same cycle as the antecedent
`define GPIO_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent checked in the cycle after the antecedent
`define GPIO_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: src/gpio_pkg.sv
// ----------------------------------------------------------------------------
// gpio_pkg
// Types and constants shared by the GPIO port, its detector and its checker.
// ----------------------------------------------------------------------------
`default_nettype none

package gpio_pkg;

	localparam int unsigned PINS      = 32;
	localparam int unsigned MODE_W    = 2;
	localparam int unsigned HALF_PINS = PINS / 2;
	localparam int unsigned CMD_W     = 2;
	localparam int unsigned IDX_W     = 3;

	// s_axis_tdata layout
	localparam int unsigned IN_DATA_W = 72;
	// m_axis_tdata layout
	localparam int unsigned OUT_DATA_W = 104;

	typedef logic [PINS-1:0] word_t;

	typedef enum logic [CMD_W-1:0] {
		CMD_TICK  = 2'd0,
		CMD_READ  = 2'd1,
		CMD_WRITE = 2'd2
	} cmd_t;

	typedef enum logic [IDX_W-1:0] {
		REG_DATA      = 3'd0,
		REG_DIR       = 3'd1,
		REG_PAD       = 3'd2,
		REG_ICR_LOW   = 3'd3,
		REG_ICR_HIGH  = 3'd4,
		REG_MASK      = 3'd5,
		REG_STATUS    = 3'd6,
		REG_BOTH_EDGE = 3'd7
	} reg_idx_t;

	typedef enum logic [MODE_W-1:0] {
		MODE_LOW  = 2'd0,
		MODE_HIGH = 2'd1,
		MODE_RISE = 2'd2,
		MODE_FALL = 2'd3
	} det_mode_t;

	// Detection set-up handed to the detector
	typedef struct packed {
		word_t icr_low;
		word_t icr_high;
		word_t both_edge;
	} det_cfg_t;

endpackage

`default_nettype wire

// File: src/gpio_irq_det.sv
// ----------------------------------------------------------------------------
// gpio_irq_det
// Per-pin level and edge detection against the previous pad sample.
// ----------------------------------------------------------------------------
`default_nettype none

module gpio_irq_det (
	input  var gpio_pkg::det_cfg_t cfg,
	input  var gpio_pkg::word_t    cur,
	input  var gpio_pkg::word_t    prev,
	output var gpio_pkg::word_t    hits
);

	gpio_pkg::word_t rise;
	gpio_pkg::word_t fall;

	assign rise = cur & ~prev;
	assign fall = ~cur & prev;

	always_comb begin
		gpio_pkg::det_mode_t mode;
		hits = '0;
		for (int unsigned p = 0; p < gpio_pkg::PINS; p++) begin
			if (p < gpio_pkg::HALF_PINS)
				mode = gpio_pkg::det_mode_t'(cfg.icr_low[p*gpio_pkg::MODE_W +: gpio_pkg::MODE_W]);
			else
				mode = gpio_pkg::det_mode_t'(
					cfg.icr_high[(p-gpio_pkg::HALF_PINS)*gpio_pkg::MODE_W +: gpio_pkg::MODE_W]);
			if (cfg.both_edge[p]) begin
				hits[p] = rise[p] | fall[p];
			end else begin
				unique case (mode)
					gpio_pkg::MODE_LOW:  hits[p] = ~cur[p];
					gpio_pkg::MODE_HIGH: hits[p] = cur[p];
					gpio_pkg::MODE_RISE: hits[p] = rise[p];
					gpio_pkg::MODE_FALL: hits[p] = fall[p];
					default:             hits[p] = 1'b0;
				endcase
			end
		end
	end

endmodule

`default_nettype wire

// File: src/gpio_port_with_pin_interrupts.sv
// The result is registered and presented in the cycle after its input transaction.
// Throughput: one transaction per cycle; the output register frees on the
// same edge it is taken, so the input stalls only while the output stalls.
// All per-pin logic is bitwise, one pass between port and register.
// Reset (arst_n low) clears every register, output valid and all state.
// ----------------------------------------------------------------------------
// gpio_port_with_pin_interrupts
// 32-pin GPIO port: register access and pad sampling with sticky interrupts.
// ----------------------------------------------------------------------------
`default_nettype none

module gpio_port_with_pin_interrupts (
	input  var logic                             clk,
	input  var logic                             arst_n,
	input  var logic                             s_axis_tvalid,
	output var logic                             s_axis_tready,
	// reg_index[2:0], write_data[34:3], pad_levels[66:35], zero fill
	input  var logic [gpio_pkg::IN_DATA_W-1:0]   s_axis_tdata,
	// cmd[1:0]
	input  var logic [gpio_pkg::CMD_W-1:0]       s_axis_tuser,
	output var logic                             m_axis_tvalid,
	input  var logic                             m_axis_tready,
	// read_data[31:0], pin_drive[63:32], pin_enable[95:64], irq[96], zero fill
	output var logic [gpio_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);

	gpio_pkg::word_t data_q, dir_q, icr_low_q, icr_high_q;
	gpio_pkg::word_t mask_q, status_q, both_q, last_pad_q;
	gpio_pkg::word_t data_d, dir_d, icr_low_d, icr_high_d;
	gpio_pkg::word_t mask_d, status_d, both_d, last_pad_d;
	gpio_pkg::word_t rdata;
	gpio_pkg::word_t hits;
	gpio_pkg::det_cfg_t det_cfg;

	gpio_pkg::cmd_t     cmd;
	gpio_pkg::reg_idx_t idx;
	gpio_pkg::word_t    wdata;
	gpio_pkg::word_t    pads;

	logic accept;
	logic out_valid_q;
	logic [gpio_pkg::OUT_DATA_W-1:0] out_data_q;

	assign cmd   = gpio_pkg::cmd_t'(s_axis_tuser);
	assign idx   = gpio_pkg::reg_idx_t'(s_axis_tdata[2:0]);
	assign wdata = s_axis_tdata[34:3];
	assign pads  = s_axis_tdata[66:35];

	assign s_axis_tready = !out_valid_q || m_axis_tready;
	assign accept        = s_axis_tvalid && s_axis_tready;

	assign det_cfg.icr_low   = icr_low_q;
	assign det_cfg.icr_high  = icr_high_q;
	assign det_cfg.both_edge = both_q;

	gpio_irq_det u_det (
		.cfg  (det_cfg),
		.cur  (pads),
		.prev (last_pad_q),
		.hits (hits)
	);

	always_comb begin
		data_d     = data_q;
		dir_d      = dir_q;
		icr_low_d  = icr_low_q;
		icr_high_d = icr_high_q;
		mask_d     = mask_q;
		status_d   = status_q;
		both_d     = both_q;
		last_pad_d = last_pad_q;
		rdata      = '0;
		unique case (cmd)
			gpio_pkg::CMD_TICK: begin
				status_d   = status_q | hits;
				last_pad_d = pads;
			end
			gpio_pkg::CMD_READ: begin
				unique case (idx)
					gpio_pkg::REG_DATA:      rdata = (data_q & dir_q) | (last_pad_q & ~dir_q);
					gpio_pkg::REG_DIR:       rdata = dir_q;
					gpio_pkg::REG_PAD:       rdata = last_pad_q;
					gpio_pkg::REG_ICR_LOW:   rdata = icr_low_q;
					gpio_pkg::REG_ICR_HIGH:  rdata = icr_high_q;
					gpio_pkg::REG_MASK:      rdata = mask_q;
					gpio_pkg::REG_STATUS:    rdata = status_q;
					gpio_pkg::REG_BOTH_EDGE: rdata = both_q;
					default:                 rdata = '0;
				endcase
			end
			gpio_pkg::CMD_WRITE: begin
				unique case (idx)
					gpio_pkg::REG_DATA:      data_d     = wdata;
					gpio_pkg::REG_DIR:       dir_d      = wdata;
					gpio_pkg::REG_PAD:       ;
					gpio_pkg::REG_ICR_LOW:   icr_low_d  = wdata;
					gpio_pkg::REG_ICR_HIGH:  icr_high_d = wdata;
					gpio_pkg::REG_MASK:      mask_d     = wdata;
					gpio_pkg::REG_STATUS:    status_d   = status_q & ~wdata;
					gpio_pkg::REG_BOTH_EDGE: both_d     = wdata;
					default:                 ;
				endcase
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			data_q     <= '0;
			dir_q      <= '0;
			icr_low_q  <= '0;
			icr_high_q <= '0;
			mask_q     <= '0;
			status_q   <= '0;
			both_q     <= '0;
			last_pad_q <= '0;
		end else if (accept) begin
			data_q     <= data_d;
			dir_q      <= dir_d;
			icr_low_q  <= icr_low_d;
			icr_high_q <= icr_high_d;
			mask_q     <= mask_d;
			status_q   <= status_d;
			both_q     <= both_d;
			last_pad_q <= last_pad_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s_axis_tready) begin
			out_valid_q <= s_axis_tvalid;
		end
	end

	// Result reflects state after the transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_data_q <= '0;
		end else if (accept) begin
			out_data_q <= {7'd0, |(status_d & mask_d), dir_d, data_d, rdata};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

endmodule

`default_nettype wire

// File: src/gpio_port_checker.sv
// ----------------------------------------------------------------------------
// gpio_port_checker
// Port-level checks on the GPIO port, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module gpio_port_checker (
	input var logic                             clk,
	input var logic                             arst_n,
	input var logic                             s_axis_tvalid,
	input var logic                             s_axis_tready,
	input var logic [gpio_pkg::IN_DATA_W-1:0]   s_axis_tdata,
	input var logic [gpio_pkg::CMD_W-1:0]       s_axis_tuser,
	input var logic                             m_axis_tvalid,
	input var logic                             m_axis_tready,
	input var logic [gpio_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);

	logic acc;
	logic is_read;
	logic is_write;

	assign acc      = s_axis_tvalid && s_axis_tready;
	assign is_read  = s_axis_tuser == gpio_pkg::CMD_READ;
	assign is_write = s_axis_tuser == gpio_pkg::CMD_WRITE;

	`GPIO_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
		m_axis_tvalid && $stable(m_axis_tdata), "output transaction dropped or changed")

	`GPIO_ASSERT_NOW(a_ready_when_empty, !m_axis_tvalid, s_axis_tready,
		"input stalled with empty output register")

	`GPIO_ASSERT_NEXT(a_rdata_zero, acc && !is_read,
		m_axis_tvalid && (m_axis_tdata[31:0] == '0), "read_data nonzero on non-read")

	`GPIO_ASSERT_NEXT(a_dir_write, acc && is_write && (s_axis_tdata[2:0] == gpio_pkg::REG_DIR),
		m_axis_tdata[95:64] == $past(s_axis_tdata[34:3]), "pin_enable not updated by write")

	`GPIO_ASSERT_NEXT(a_mask_off, acc && is_write
		&& (s_axis_tdata[2:0] == gpio_pkg::REG_MASK) && (s_axis_tdata[34:3] == '0),
		!m_axis_tdata[96], "irq raised with all pins masked")

endmodule

bind gpio_port_with_pin_interrupts gpio_port_checker u_gpio_port_checker (.*);

`default_nettype wire

// File: tb/sv/tb_gpio_port_with_pin_interrupts.sv
// ----------------------------------------------------------------------------
// tb_gpio_port_with_pin_interrupts
// Drives register reads, register writes, pad sample ticks and unused commands
// into the GPIO port and checks every response against a cycle-free model of the port
// state: drive and enable words, interrupt status and the irq line.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_gpio_port_with_pin_interrupts;

	localparam logic [gpio_pkg::CMD_W-1:0] CMD_UNUSED   = 2'd3;
	localparam int                         LIMIT_CYCLES = 200000;
	localparam gpio_pkg::word_t            ALL_ONES     = 32'hFFFF_FFFF;

	typedef struct {
		gpio_pkg::word_t read_data;
		gpio_pkg::word_t pin_drive;
		gpio_pkg::word_t pin_enable;
		logic            irq;
	} port_response_t;

	logic                                clk = 1'b0;
	logic                                arst_n = 1'b0;
	logic                                s_axis_tvalid = 1'b0;
	logic                                s_axis_tready;
	// reg_index[2:0], write_data[34:3], pad_levels[66:35], zero fill
	logic [gpio_pkg::IN_DATA_W-1:0]      s_axis_tdata = '0;
	// cmd[1:0]
	logic [gpio_pkg::CMD_W-1:0]          s_axis_tuser = '0;
	logic                                m_axis_tvalid;
	logic                                m_axis_tready = 1'b0;
	// read_data[31:0], pin_drive[63:32], pin_enable[95:64], irq[96], zero fill
	logic [gpio_pkg::OUT_DATA_W-1:0]     m_axis_tdata;

	// Model of the port registers
	gpio_pkg::word_t gp_data, gp_dir, gp_icr_lo, gp_icr_hi;
	gpio_pkg::word_t gp_mask, gp_status, gp_both, gp_pads_prev;

	port_response_t pending_responses[$];

	int src_idle_pct = 0;
	int snk_idle_pct = 0;
	int hold_cycles  = 0;
	int cycle_count  = 0;
	int error_count  = 0;
	int checked_count = 0;
	int n_ticks = 0, n_reads = 0, n_writes = 0, n_unused = 0;

	gpio_port_with_pin_interrupts DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("%0t: timeout after %0d cycles", $time, cycle_count);
			$display("FAILED: results differ");
			$finish;
		end
	end

	// Receiver: random stalls, or a long hold-off when one is requested
	always @(posedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles = hold_cycles - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);
		end
	end

	function automatic gpio_pkg::word_t pin_hits(gpio_pkg::word_t cur, gpio_pkg::word_t prev);
		gpio_pkg::word_t     rise;
		gpio_pkg::word_t     fall;
		gpio_pkg::word_t     hits;
		gpio_pkg::det_mode_t mode;
		rise = cur & ~prev;
		fall = ~cur & prev;
		hits = '0;
		for (int pin = 0; pin < gpio_pkg::PINS; pin++) begin
			if (pin < gpio_pkg::HALF_PINS)
				mode = gpio_pkg::det_mode_t'(
					gp_icr_lo[gpio_pkg::MODE_W*pin +: gpio_pkg::MODE_W]);
			else
				mode = gpio_pkg::det_mode_t'(
					gp_icr_hi[gpio_pkg::MODE_W*(pin-gpio_pkg::HALF_PINS) +: gpio_pkg::MODE_W]);
			if (gp_both[pin])
				hits[pin] = rise[pin] | fall[pin];
			else begin
				case (mode)
					gpio_pkg::MODE_LOW:  hits[pin] = ~cur[pin];
					gpio_pkg::MODE_HIGH: hits[pin] = cur[pin];
					gpio_pkg::MODE_RISE: hits[pin] = rise[pin];
					default:             hits[pin] = fall[pin];
				endcase
			end
		end
		return hits;
	endfunction

	task automatic predict_port_response(input logic [gpio_pkg::CMD_W-1:0] cmd,
			input gpio_pkg::reg_idx_t idx, input gpio_pkg::word_t wdata,
			input gpio_pkg::word_t pads);
		port_response_t rsp;
		rsp.read_data = '0;
		if (cmd == gpio_pkg::CMD_TICK) begin
			gp_status    = gp_status | pin_hits(pads, gp_pads_prev);
			gp_pads_prev = pads;
			n_ticks++;
		end else if (cmd == gpio_pkg::CMD_READ) begin
			case (idx)
				gpio_pkg::REG_DATA:
					rsp.read_data = (gp_data & gp_dir) | (gp_pads_prev & ~gp_dir);
				gpio_pkg::REG_DIR:      rsp.read_data = gp_dir;
				gpio_pkg::REG_PAD:      rsp.read_data = gp_pads_prev;
				gpio_pkg::REG_ICR_LOW:  rsp.read_data = gp_icr_lo;
				gpio_pkg::REG_ICR_HIGH: rsp.read_data = gp_icr_hi;
				gpio_pkg::REG_MASK:     rsp.read_data = gp_mask;
				gpio_pkg::REG_STATUS:   rsp.read_data = gp_status;
				default:                rsp.read_data = gp_both;
			endcase
			n_reads++;
		end else if (cmd == gpio_pkg::CMD_WRITE) begin
			case (idx)
				gpio_pkg::REG_DATA:     gp_data = wdata;
				gpio_pkg::REG_DIR:      gp_dir = wdata;
				gpio_pkg::REG_PAD:      ;
				gpio_pkg::REG_ICR_LOW:  gp_icr_lo = wdata;
				gpio_pkg::REG_ICR_HIGH: gp_icr_hi = wdata;
				gpio_pkg::REG_MASK:     gp_mask = wdata;
				gpio_pkg::REG_STATUS:   gp_status = gp_status & ~wdata;
				default:                gp_both = wdata;
			endcase
			n_writes++;
		end else begin
			n_unused++;
		end
		rsp.pin_drive  = gp_data;
		rsp.pin_enable = gp_dir;
		rsp.irq        = |(gp_status & gp_mask);
		pending_responses.push_back(rsp);
	endtask

	// Called at a rising edge; returns at the edge where the transaction is taken
	task automatic send_item(input logic [gpio_pkg::CMD_W-1:0] cmd,
			input gpio_pkg::reg_idx_t idx, input gpio_pkg::word_t wdata,
			input gpio_pkg::word_t pads);
		while ($urandom_range(99) < src_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= cmd;
		s_axis_tdata  <= {5'b0, pads, wdata, idx};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		predict_port_response(cmd, idx, wdata, pads);
	endtask

	task automatic wait_drain();
		s_axis_tvalid <= 1'b0;
		while (pending_responses.size() != 0)
			@(posedge clk);
	endtask

	task automatic check_field(input string name, input gpio_pkg::word_t exp_v,
			input gpio_pkg::word_t act_v);
		if (exp_v !== act_v) begin
			$display("%0t: %s mismatch, expected %h actual %h", $time, name, exp_v, act_v);
			error_count++;
		end
	endtask

	always @(posedge clk) begin
		port_response_t exp_rsp;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_responses.size() == 0) begin
				$display("%0t: unexpected response, expected none actual %h", $time,
					m_axis_tdata);
				error_count++;
			end else begin
				exp_rsp = pending_responses.pop_front();
				check_field("read_data", exp_rsp.read_data, m_axis_tdata[31:0]);
				check_field("pin_drive", exp_rsp.pin_drive, m_axis_tdata[63:32]);
				check_field("pin_enable", exp_rsp.pin_enable, m_axis_tdata[95:64]);
				check_field("irq", gpio_pkg::word_t'(exp_rsp.irq),
					gpio_pkg::word_t'(m_axis_tdata[96]));
				checked_count++;
			end
		end
	end

	task automatic test_register_access();
		send_item(gpio_pkg::CMD_READ, gpio_pkg::REG_MASK, '0, '0);
		send_item(gpio_pkg::CMD_WRITE, gpio_pkg::REG_DATA, ALL_ONES, '0);
		send_item(gpio_pkg::CMD_WRITE, gpio_pkg::REG_DIR, 32'hFFFF_0000, '0);
		send_item(gpio_pkg::CMD_TICK, gpio_pkg::REG_DATA, '0, 32'hA5A5_A5A5);
		// output pins read back the drive word, input pins the pads
		send_item(gpio_pkg::CMD_READ, gpio_pkg::REG_DATA, '0, '0);
		send_item(gpio_pkg::CMD_WRITE, gpio_pkg::REG_PAD, 32'h1234_5678, '0);
		send_item(gpio_pkg::CMD_READ, gpio_pkg::REG_PAD, '0, ALL_ONES);
	endtask

	task automatic test_level_detect();
		send_item(gpio_pkg::CMD_WRITE, gpio_pkg::REG_ICR_LOW, 32'h5555_5555, '0);
		send_item(gpio_pkg::CMD_WRITE, gpio_pkg::REG_ICR_HIGH, '0, '0);
		send_item(gpio_pkg::CMD_WRITE, gpio_pkg::REG_STATUS, ALL_ONES, '0);
		send_item(gpio_pkg::CMD_WRITE, gpio_pkg::REG_MASK, ALL_ONES, '0);
		send_item(gpio_pkg::CMD_TICK, gpio_pkg::REG_DATA, '0, 32'h0000_FFFF);
		send_item(gpio_pkg::CMD_WRITE, gpio_pkg::REG_STATUS, ALL_ONES, '0);
		// level still held, so the cleared bits come straight back
		send_item(gpio_pkg::CMD_TICK, gpio_pkg::REG_DATA, '0, 32'h0000_FFFF);
		send_item(gpio_pkg::CMD_READ, gpio_pkg::REG_STATUS, '0, '0);
	endtask

	task automatic test_edge_detect();
		send_item(gpio_pkg::CMD_WRITE, gpio_pkg::REG_ICR_LOW, 32'hAAAA_AAAA, '0);
		send_item(gpio_pkg::CMD_WRITE, gpio_pkg::REG_ICR_HIGH, ALL_ONES, '0);
		send_item(gpio_pkg::CMD_WRITE, gpio_pkg::REG_STATUS, ALL_ONES, '0);
		// first tick moves both halves the wrong way, the second the right way
		send_item(gpio_pkg::CMD_TICK, gpio_pkg::REG_DATA, '0, 32'hFFFF_0000);
		send_item(gpio_pkg::CMD_TICK, gpio_pkg::REG_DATA, '0, 32'h0000_FFFF);
		send_item(gpio_pkg::CMD_READ, gpio_pkg::REG_STATUS, '0, '0);
	endtask

	task automatic test_both_edge();
		send_item(gpio_pkg::CMD_WRITE, gpio_pkg::REG_BOTH_EDGE, 32'hFF00_FF00, '0);
		send_item(gpio_pkg::CMD_WRITE, gpio_pkg::REG_STATUS, ALL_ONES, '0);
		send_item(gpio_pkg::CMD_TICK, gpio_pkg::REG_DATA, '0, 32'h00FF_00FF);
		send_item(gpio_pkg::CMD_READ, gpio_pkg::REG_BOTH_EDGE, '0, '0);
	endtask

	task automatic test_unused_command();
		send_item(CMD_UNUSED, gpio_pkg::REG_STATUS, ALL_ONES, ALL_ONES);
		send_item(gpio_pkg::CMD_READ, gpio_pkg::REG_STATUS, '0, '0);
	endtask

	task automatic test_random_traffic(input int n_items, input int src_pct, input int snk_pct);
		logic [gpio_pkg::CMD_W-1:0] cmd;
		gpio_pkg::reg_idx_t         idx;
		gpio_pkg::word_t            wdata;
		gpio_pkg::word_t            pads;
		int                         pick;
		src_idle_pct = src_pct;
		snk_idle_pct = snk_pct;
		repeat (n_items) begin
			pick = $urandom_range(99);
			if (pick < 40)      cmd = gpio_pkg::CMD_TICK;
			else if (pick < 70) cmd = gpio_pkg::CMD_READ;
			else if (pick < 96) cmd = gpio_pkg::CMD_WRITE;
			else                cmd = CMD_UNUSED;
			idx = gpio_pkg::reg_idx_t'($urandom_range(7));
			case ($urandom_range(9))
				0:       wdata = '0;
				1:       wdata = ALL_ONES;
				default: wdata = $urandom;
			endcase
			// mostly held or slowly changing pads so levels persist and edges stay sparse
			case ($urandom_range(9))
				0:          pads = '0;
				1:          pads = ALL_ONES;
				2, 3, 4, 5: pads = gp_pads_prev;
				6, 7:       pads = gp_pads_prev ^ (gpio_pkg::word_t'(1) << $urandom_range(31));
				default:    pads = $urandom;
			endcase
			send_item(cmd, idx, wdata, pads);
		end
	endtask

	task automatic test_backpressure();
		src_idle_pct = 0;
		snk_idle_pct = 0;
		hold_cycles  = 60;
		test_random_traffic(20, 0, 0);
		wait_drain();
	endtask

	initial begin
		gp_data = '0; gp_dir = '0; gp_icr_lo = '0; gp_icr_hi = '0;
		gp_mask = '0; gp_status = '0; gp_both = '0; gp_pads_prev = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		src_idle_pct = 20;
		snk_idle_pct = 20;
		test_register_access();
		test_level_detect();
		test_edge_detect();
		test_both_edge();
		test_unused_command();
		wait_drain();

		test_backpressure();
		test_random_traffic(180, 31, 88);
		wait_drain();
		test_random_traffic(180, 88, 31);
		wait_drain();
		test_random_traffic(170, 0, 0);
		wait_drain();
		repeat (5) @(posedge clk);

		$display("Covered %0d ticks, %0d reads, %0d writes, %0d unused commands",
			n_ticks, n_reads, n_writes, n_unused);
		$display("%0d responses checked, %0d mismatches", checked_count, error_count);
		if (error_count == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

`default_nettype wire
